// ----- src/r2fft_pkg.sv -----
// Shared types, constants and the twiddle ROM for the radix-2 FFT core.
// No dependencies.
`timescale 1ns / 1ps
package r2fft_pkg;

  localparam int InBits   = 16;
  localparam int DataBits = 23;
  localparam int RomLog2  = 6;

  typedef enum logic [1:0] {
    REG_INVERSE = 2'd0,
    REG_SCALE   = 2'd1,
    REG_LOG2    = 2'd2
  } reg_index_e;

  typedef struct packed {
    logic                     frame_end;
    logic                     inverse;
    logic                     scale;
    logic [2:0]               log2n;
    logic [RomLog2-1:0]       addr;
    logic signed [InBits-1:0] im;
    logic signed [InBits-1:0] re;
  } load_word_t;

  function automatic logic signed [33:0] quarter_cos(input logic [4:0] k);
    logic signed [33:0] v;
    unique case (k)
      5'd0:    v = 34'sd2147483648;
      5'd1:    v = 34'sd2137142927;
      5'd2:    v = 34'sd2106220352;
      5'd3:    v = 34'sd2055013723;
      5'd4:    v = 34'sd1984016189;
      5'd5:    v = 34'sd1893911494;
      5'd6:    v = 34'sd1785567396;
      5'd7:    v = 34'sd1660027308;
      5'd8:    v = 34'sd1518500250;
      5'd9:    v = 34'sd1362349203;
      5'd10:   v = 34'sd1193077991;
      5'd11:   v = 34'sd1012316784;
      5'd12:   v = 34'sd821806413;
      5'd13:   v = 34'sd623381598;
      5'd14:   v = 34'sd418953276;
      5'd15:   v = 34'sd210490206;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [33:0] full_cos(input logic [5:0] j);
    logic signed [33:0] v;
    if (j <= 6'd16) begin
      v = quarter_cos(5'(j));
    end else if (j <= 6'd32) begin
      v = -quarter_cos(5'(6'd32 - j));
    end else if (j <= 6'd48) begin
      v = -quarter_cos(5'(j - 6'd32));
    end else begin
      v = quarter_cos(5'(7'd64 - {1'b0, j}));
    end
    return v;
  endfunction

  function automatic logic signed [24:0] twiddle(input logic [5:0] j, input int bits);
    logic signed [33:0] v;
    logic signed [33:0] lim;
    v   = (full_cos(j) + (34'sd1 <<< (31 - bits))) >>> (32 - bits);
    lim = (34'sd1 <<< (bits - 1)) - 34'sd1;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return 25'(v);
  endfunction

endpackage

// ----- src/r2fft_front.sv -----
// Input side of the FFT core: configuration registers, frame counting and
// bit-reversed addressing. Depends on r2fft_pkg.
`timescale 1ns / 1ps
module r2fft_front import r2fft_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [2:0]               cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [InBits-1:0] in_re_i,
  input  logic signed [InBits-1:0] in_im_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output load_word_t               push_data_o
);

  localparam int CapRaw = $clog2(MAX_POINTS + 1) - 1;
  localparam logic [2:0] Cap = 3'((CapRaw > RomLog2) ? RomLog2 : CapRaw);

  logic       inverse_q, scale_q;
  logic [2:0] log2_q;
  logic [6:0] count_q;
  logic [2:0] l_act;
  logic [6:0] n_act;
  logic [5:0] rev;
  logic       accept, frame_end;

  assign l_act = (log2_q > Cap) ? Cap : log2_q;
  assign n_act = 7'd1 << l_act;
  assign accept = in_valid_i && push_ready_i;
  assign frame_end = (count_q + 7'd1) >= n_act;

  always_comb begin
    for (int b = 0; b < 6; b++) begin
      rev[b] = count_q[5 - b];
    end
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign push_data_o  = '{frame_end: frame_end, inverse: inverse_q, scale: scale_q,
                          log2n: l_act, addr: rev >> (3'd6 - l_act),
                          im: in_im_i, re: in_re_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q <= 1'b0;
      scale_q   <= 1'b1;
      log2_q    <= 3'd6;
      count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_INVERSE: inverse_q <= cfg_data_i[0];
          REG_SCALE:   scale_q <= cfg_data_i[0];
          REG_LOG2: begin
            log2_q  <= cfg_data_i;
            count_q <= '0;
          end
          default: ;
        endcase
      end else if (accept) begin
        count_q <= frame_end ? 7'd0 : count_q + 7'd1;
      end
    end
  end

endmodule

// ----- src/r2fft_queue.sv -----
// Small first-in first-out queue between the front and back of the FFT core.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module r2fft_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      fill_q;
  logic             push, pop;

  assign push_ready_o = fill_q != (PW+1)'(DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_data_o   = slot_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      fill_q <= fill_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- src/r2fft_back.sv -----
// Back end of the FFT core: sample memory, one shared butterfly with a single
// multiplier, and the output register. Depends on r2fft_pkg.
`timescale 1ns / 1ps
module r2fft_back import r2fft_pkg::*; #(
  parameter int MAX_POINTS   = 64,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  load_word_t                 pop_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [DataBits-1:0] out_re_o,
  output logic signed [DataBits-1:0] out_im_o,
  output logic                       out_last_o
);

  localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int TW = TWIDDLE_BITS;
  localparam int DW = DataBits;
  localparam int PW = DW + TW;

  typedef enum logic [3:0] {
    ST_LOAD, ST_BF_RD, ST_BF_LATCH, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4,
    ST_WA, ST_WC, ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD
  } state_e;

  state_e state_q;
  logic [2*DW-1:0] mem [MAX_POINTS];
  logic [2*DW-1:0] rda_q, rdc_q;
  logic [AW-1:0]   ra, rc, idx_q, bf_q, hmask, kk, a_addr, c_addr;
  logic [2:0]      s_q, l_q;
  logic            inv_q, scl_q, bypass_q;
  logic [5:0]      j;
  logic signed [DW-1:0] ar_q, ai_q, cr_q, ci_q, pr_q, pi_q, pr_v, pi_v;
  logic signed [TW-1:0] tc_q, ts_q, mul_y;
  logic signed [DW-1:0] mul_x;
  logic signed [PW-1:0] p_q;
  logic signed [PW:0]   acc_q, diff, summ;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [2*DW-1:0] mem_wd;
  logic [6:0]      n_v;
  logic [AW-1:0]   half_last;
  logic signed [DW:0] sre, sim;

  assign hmask  = (AW'(1) << (s_q - 3'd1)) - AW'(1);
  assign kk     = bf_q & hmask;
  assign a_addr = ((bf_q >> (s_q - 3'd1)) << s_q) | kk;
  assign c_addr = a_addr | (AW'(1) << (s_q - 3'd1));
  assign j      = 6'(kk) << (3'd6 - s_q);
  assign n_v    = 7'd1 << l_q;
  assign half_last = AW'((n_v >> 1) - 7'd1);

  assign ra = (state_q == ST_OUT_RD) ? idx_q : a_addr;
  assign rc = c_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rda_q <= mem[ra];
    rdc_q <= mem[rc];
  end

  always_comb begin
    unique case (state_q)
      ST_M0:   begin mul_x = cr_q; mul_y = tc_q; end
      ST_M1:   begin mul_x = ci_q; mul_y = ts_q; end
      ST_M2:   begin mul_x = ci_q; mul_y = tc_q; end
      default: begin mul_x = cr_q; mul_y = ts_q; end
    endcase
  end

  assign diff = acc_q - (PW+1)'(p_q);
  assign summ = acc_q + (PW+1)'(p_q);
  assign pr_v = bypass_q ? cr_q : pr_q;
  assign pi_v = bypass_q ? ci_q : pi_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = a_addr;
    mem_wd = {ai_q + pi_v, ar_q + pr_v};
    if (state_q == ST_LOAD && pop_valid_i) begin
      mem_we = 1'b1;
      mem_wa = pop_data_i.addr[AW-1:0];
      mem_wd = {{(DW-InBits){pop_data_i.im[InBits-1]}}, pop_data_i.im,
                {(DW-InBits){pop_data_i.re[InBits-1]}}, pop_data_i.re};
    end else if (state_q == ST_WA) begin
      mem_we = 1'b1;
    end else if (state_q == ST_WC) begin
      mem_we = 1'b1;
      mem_wa = c_addr;
      mem_wd = {ai_q - pi_v, ar_q - pr_v};
    end
  end

  always_comb begin
    sre = (DW+1)'($signed(rda_q[DW-1:0]));
    sim = (DW+1)'($signed(rda_q[2*DW-1:DW]));
    if (inv_q && scl_q && l_q != 3'd0) begin
      sre = (sre + ((DW+1)'(1) <<< (l_q - 3'd1))) >>> l_q;
      sim = (sim + ((DW+1)'(1) <<< (l_q - 3'd1))) >>> l_q;
    end
  end

  assign pop_ready_o = state_q == ST_LOAD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_o <= 1'b0;
      s_q <= '0; l_q <= '0; bf_q <= '0; idx_q <= '0;
      inv_q <= 1'b0; scl_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (pop_valid_i && pop_data_i.frame_end) begin
            l_q   <= pop_data_i.log2n;
            inv_q <= pop_data_i.inverse;
            scl_q <= pop_data_i.scale;
            s_q   <= 3'd1;
            bf_q  <= '0;
            idx_q <= '0;
            state_q <= (pop_data_i.log2n == 3'd0) ? ST_OUT_RD : ST_BF_RD;
          end
        end
        ST_BF_RD: state_q <= ST_BF_LATCH;
        ST_BF_LATCH: begin
          ar_q <= $signed(rda_q[DW-1:0]);
          ai_q <= $signed(rda_q[2*DW-1:DW]);
          cr_q <= $signed(rdc_q[DW-1:0]);
          ci_q <= $signed(rdc_q[2*DW-1:DW]);
          tc_q <= TW'(twiddle(j, TW));
          ts_q <= inv_q ? TW'(twiddle(j + 6'd48, TW)) : TW'(-twiddle(j + 6'd48, TW));
          bypass_q <= j == 6'd0;
          state_q <= ST_M0;
        end
        ST_M0: begin
          p_q <= mul_x * mul_y;
          state_q <= ST_M1;
        end
        ST_M1: begin
          acc_q <= (PW+1)'(p_q);
          p_q <= mul_x * mul_y;
          state_q <= ST_M2;
        end
        ST_M2: begin
          pr_q <= DW'((diff + ((PW+1)'(1) <<< (TW - 2))) >>> (TW - 1));
          p_q <= mul_x * mul_y;
          state_q <= ST_M3;
        end
        ST_M3: begin
          acc_q <= (PW+1)'(p_q);
          p_q <= mul_x * mul_y;
          state_q <= ST_M4;
        end
        ST_M4: begin
          pi_q <= DW'((summ + ((PW+1)'(1) <<< (TW - 2))) >>> (TW - 1));
          state_q <= ST_WA;
        end
        ST_WA: state_q <= ST_WC;
        ST_WC: begin
          if (bf_q == half_last) begin
            bf_q <= '0;
            if (s_q == l_q) begin
              state_q <= ST_OUT_RD;
            end else begin
              s_q <= s_q + 3'd1;
              state_q <= ST_BF_RD;
            end
          end else begin
            bf_q <= bf_q + AW'(1);
            state_q <= ST_BF_RD;
          end
        end
        ST_OUT_RD: state_q <= ST_OUT_LD;
        ST_OUT_LD: begin
          out_re_o    <= DW'(sre);
          out_im_o    <= DW'(sim);
          out_last_o  <= 7'(idx_q) == n_v - 7'd1;
          out_valid_o <= 1'b1;
          state_q     <= ST_OUT_HOLD;
        end
        ST_OUT_HOLD: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            idx_q <= idx_q + AW'(1);
            state_q <= out_last_o ? ST_LOAD : ST_OUT_RD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

endmodule

// ----- src/radix2_fft_ifft_core.sv -----
// Top level of the radix-2 FFT / inverse FFT core.
// Depends on r2fft_pkg, r2fft_front, r2fft_queue and r2fft_back.
// A frame of N = 2^L complex words is loaded at one word a cycle while the
// queue has room, then transformed in place with one butterfly unit (one
// shared multiplier; each butterfly reads its pair, latches it, forms four
// products and writes its two results), then the N bins leave in natural
// order, each held until taken, the last marked by tlast. Once the
// four-word queue is full, input words are refused while a transform or its
// output is running.
`timescale 1ns / 1ps
module radix2_fft_ifft_core import r2fft_pkg::*; #(
  parameter int MAX_POINTS   = 64,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // sample_re, sample_im
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // bin_re, bin_im, two zero bits
  output logic        m_axis_tlast_o
);

  localparam int QW = $bits(load_word_t);

  load_word_t push_data, pop_data;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  logic signed [DataBits-1:0] bin_re, bin_im;

  r2fft_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .in_re_i(s_axis_tdata_i[15:0]), .in_im_i(s_axis_tdata_i[31:16]),
    .push_valid_o(push_valid), .push_ready_i(push_ready), .push_data_o(push_data)
  );

  r2fft_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready), .push_data_i(push_data),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready), .pop_data_o(pop_data)
  );

  r2fft_back #(.MAX_POINTS(MAX_POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(pop_valid), .pop_ready_o(pop_ready), .pop_data_i(pop_data),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_re_o(bin_re), .out_im_o(bin_im), .out_last_o(m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, bin_im, bin_re};

endmodule
